FILE: rtl/core/scc_pkg.sv
// scc_pkg: shared types and constants for the stick channel conditioner.
// Used by every module in rtl/core; no dependencies.
package scc_pkg;

  localparam int AXIS_W     = 11;
  localparam int ACC_W      = 20;
  localparam int LEVEL_W    = 10;
  localparam int DUTY_W     = 8;
  localparam int SEQ_W      = 8;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 3;

  localparam int MILLI_FULL = 1000000;
  localparam int AXIS_LIMIT = 1000;
  localparam int AUX_LIMIT  = 500;

  localparam logic [9:0] DEADZONE_RESET  = 10'd150;
  localparam logic [9:0] THRESHOLD_RESET = 10'd100;

  // floor(acc / 1000) = (acc * Q_MUL) >> Q_SHIFT for acc up to full scale
  localparam logic [20:0] Q_MUL   = 21'd1073742;
  localparam int          Q_SHIFT = 30;
  // floor(v / 3125) = (v * D_MUL) >> D_SHIFT for v below 800000
  localparam logic [20:0] D_MUL   = 21'd1374390;
  localparam int          D_SHIFT = 32;
  localparam logic [6:0]  DUTY_NUM = 7'd51;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OFFSET_ROLL  = 3'd0,
    REG_OFFSET_PITCH = 3'd1,
    REG_OFFSET_YAW   = 3'd2,
    REG_DEADZONE     = 3'd3,
    REG_THRESHOLD    = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic signed [AXIS_W-1:0] offset_roll;
    logic signed [AXIS_W-1:0] offset_pitch;
    logic signed [AXIS_W-1:0] offset_yaw;
    logic [9:0]               deadzone;
    logic [9:0]               threshold;
  } cfg_t;

  function automatic logic signed [AXIS_W-1:0] calibrate(
    input logic signed [AXIS_W-1:0] raw,
    input logic signed [AXIS_W-1:0] off
  );
    logic signed [AXIS_W:0] diff;
    logic signed [AXIS_W-1:0] res;
    diff = (AXIS_W + 1)'(raw) - (AXIS_W + 1)'(off);
    if (diff > (AXIS_W + 1)'(AXIS_LIMIT)) begin
      res = AXIS_W'(AXIS_LIMIT);
    end else if (diff < -(AXIS_W + 1)'(AXIS_LIMIT)) begin
      res = -AXIS_W'(AXIS_LIMIT);
    end else begin
      res = diff[AXIS_W-1:0];
    end
    return res;
  endfunction

endpackage

FILE: rtl/core/scc_scale.sv
// scc_scale: maps one converter sample to -1000..999, (x - mid) * 1000 / mid,
// truncated toward zero. Depends on scc_pkg.
module scc_scale
  import scc_pkg::*;
#(
  parameter int ADC_BITS = 12
) (
  input  logic [ADC_BITS-1:0]      sample,
  output logic signed [AXIS_W-1:0] axis
);

  localparam int MID = 1 << (ADC_BITS - 1);
  localparam int PW  = ADC_BITS + 11;

  logic signed [ADC_BITS:0] diff;
  logic signed [PW-1:0]     prod;
  logic signed [PW-1:0]     bias;
  logic signed [PW-1:0]     quot;

  assign diff = $signed({1'b0, sample}) - $signed((ADC_BITS + 1)'(MID));
  assign prod = PW'(diff) * $signed(PW'(1000));
  // round toward zero on negative values
  assign bias = prod[PW-1] ? $signed(PW'(MID - 1)) : '0;
  assign quot = (prod + bias) >>> (ADC_BITS - 1);
  assign axis = quot[AXIS_W-1:0];

endmodule

FILE: rtl/core/scc_throttle.sv
// scc_throttle: throttle accumulator in milli-units, stepped by twice the
// scaled stick when it clears the threshold, clamped to 0..full scale. Uses scc_pkg.
module scc_throttle
  import scc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     load,
  input  logic signed [AXIS_W-1:0] stick,
  input  logic [9:0]               threshold,
  output logic [ACC_W-1:0]         acc
);

  logic signed [AXIS_W:0]  stick_w;
  logic signed [AXIS_W:0]  thr_s;
  logic                    move;
  logic signed [ACC_W+1:0] step;
  logic signed [ACC_W+1:0] sum;
  logic [ACC_W-1:0]        acc_next;

  assign stick_w = (AXIS_W + 1)'(stick);
  assign thr_s   = $signed({2'b00, threshold});
  assign move    = (stick_w > thr_s) || (stick_w < -thr_s);
  assign step    = move ? $signed({{(ACC_W - AXIS_W + 1){stick[AXIS_W-1]}}, stick, 1'b0})
                        : '0;
  assign sum     = $signed({2'b00, acc}) + step;

  always_comb begin
    if (sum[ACC_W+1]) begin
      acc_next = '0;
    end else if (sum > $signed((ACC_W + 2)'(MILLI_FULL))) begin
      acc_next = ACC_W'(MILLI_FULL);
    end else begin
      acc_next = sum[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (load) begin
      acc <= acc_next;
    end
  end

endmodule

FILE: rtl/core/scc_level.sv
// scc_level: throttle level (whole units, deadzone applied) and LED duty
// from the accumulator. Uses scc_pkg reciprocal constants.
module scc_level
  import scc_pkg::*;
(
  input  logic [ACC_W-1:0]   acc,
  input  logic [9:0]         deadzone,
  output logic [LEVEL_W-1:0] level,
  output logic [DUTY_W-1:0]  duty
);

  logic [40:0]        q_prod;
  logic [LEVEL_W-1:0] units;
  logic [25:0]        scaled;
  logic [19:0]        scaled_lo;
  logic [40:0]        d_prod;

  assign q_prod = 41'(acc) * 41'(Q_MUL);
  assign units  = LEVEL_W'(q_prod >> Q_SHIFT);
  // acc < deadzone*1000 is the same as floor(acc/1000) < deadzone
  assign level  = (units < deadzone) ? '0 : units;

  // acc*255/1e6 = ((acc*51) >> 6) / 3125
  assign scaled    = 26'(acc) * 26'(DUTY_NUM);
  assign scaled_lo = scaled[25:6];
  assign d_prod    = 41'(scaled_lo) * 41'(D_MUL);
  assign duty      = DUTY_W'(d_prod >> D_SHIFT);

endmodule

FILE: rtl/core/stick_channel_conditioner.sv
// Stick channel conditioner: three-register pipeline (input, scaled, result).
// An accepted frame is registered in stage A, then in B, then in the result stage C.
// Throughput: one frame per cycle when not stalled; the accumulator steps per frame.
// Stalls propagate back through the stages; bubbles are squeezed out.
// Reset clears all valid bits, the accumulator and the frame counter, and sets
// the offsets to 0, the deadzone to 150 and the rate threshold to 100.
module stick_channel_conditioner
  import scc_pkg::*;
#(
  parameter int ADC_BITS = 12
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     wr_en,
  input  logic [CFG_IDX_W-1:0]     wr_index,
  input  logic [CFG_DATA_W-1:0]    wr_data,
  input  logic                     frame_valid,
  output logic                     frame_stall,
  input  logic [ADC_BITS-1:0]      roll_adc,
  input  logic [ADC_BITS-1:0]      pitch_adc,
  input  logic [ADC_BITS-1:0]      yaw_adc,
  input  logic [ADC_BITS-1:0]      throttle_adc,
  input  logic [ADC_BITS-1:0]      aux_one_adc,
  input  logic [ADC_BITS-1:0]      aux_two_adc,
  input  logic                     button_three_level,
  input  logic                     button_four_level,
  output logic                     result_valid,
  input  logic                     result_stall,
  output logic signed [AXIS_W-1:0] raw_roll,
  output logic signed [AXIS_W-1:0] raw_pitch,
  output logic signed [AXIS_W-1:0] raw_yaw,
  output logic signed [AXIS_W-1:0] roll,
  output logic signed [AXIS_W-1:0] pitch,
  output logic signed [AXIS_W-1:0] yaw,
  output logic [LEVEL_W-1:0]       throttle,
  output logic [DUTY_W-1:0]        led_duty,
  output logic [SEQ_W-1:0]         sequence_res,
  output logic [3:0]               buttons,
  output logic signed [AXIS_W-1:0] aux_one_axis,
  output logic signed [AXIS_W-1:0] aux_two_axis
);

  cfg_t cfg;

  // stage A: input word
  logic                a_valid;
  logic [ADC_BITS-1:0] a_roll, a_pitch, a_yaw, a_throttle, a_aux_one, a_aux_two;
  logic                a_btn_three, a_btn_four;

  // stage B: scaled word
  logic                     b_valid;
  logic signed [AXIS_W-1:0] b_roll, b_pitch, b_yaw, b_aux_one, b_aux_two;
  logic [3:0]               b_buttons;
  logic [SEQ_W-1:0]         b_seq;
  logic [ACC_W-1:0]         b_acc;

  logic [SEQ_W-1:0] frame_counter;

  logic signed [AXIS_W-1:0] s_roll, s_pitch, s_yaw, s_throttle, s_aux_one, s_aux_two;
  logic [LEVEL_W-1:0]       c_level;
  logic [DUTY_W-1:0]        c_duty;

  logic c_free, b_free, a_free, a_adv, b_adv, a_load;

  assign c_free      = !result_valid || !result_stall;
  assign b_free      = !b_valid || c_free;
  assign a_free      = !a_valid || b_free;
  assign b_adv       = b_valid && c_free;
  assign a_adv       = a_valid && b_free;
  assign a_load      = frame_valid && a_free;
  assign frame_stall = !a_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.offset_roll  <= '0;
      cfg.offset_pitch <= '0;
      cfg.offset_yaw   <= '0;
      cfg.deadzone     <= DEADZONE_RESET;
      cfg.threshold    <= THRESHOLD_RESET;
    end else if (wr_en) begin
      unique case (reg_index_t'(wr_index))
        REG_OFFSET_ROLL:  cfg.offset_roll  <= $signed(wr_data);
        REG_OFFSET_PITCH: cfg.offset_pitch <= $signed(wr_data);
        REG_OFFSET_YAW:   cfg.offset_yaw   <= $signed(wr_data);
        REG_DEADZONE:     cfg.deadzone     <= wr_data[9:0];
        REG_THRESHOLD:    cfg.threshold    <= wr_data[9:0];
        default: ;
      endcase
    end
  end

  // stage A
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_free) begin
      a_valid <= frame_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_load) begin
      a_roll      <= roll_adc;
      a_pitch     <= pitch_adc;
      a_yaw       <= yaw_adc;
      a_throttle  <= throttle_adc;
      a_aux_one   <= aux_one_adc;
      a_aux_two   <= aux_two_adc;
      a_btn_three <= button_three_level;
      a_btn_four  <= button_four_level;
    end
  end

  scc_scale #(.ADC_BITS(ADC_BITS)) u_scale_roll     (.sample(a_roll),     .axis(s_roll));
  scc_scale #(.ADC_BITS(ADC_BITS)) u_scale_pitch    (.sample(a_pitch),    .axis(s_pitch));
  scc_scale #(.ADC_BITS(ADC_BITS)) u_scale_yaw      (.sample(a_yaw),      .axis(s_yaw));
  scc_scale #(.ADC_BITS(ADC_BITS)) u_scale_throttle (.sample(a_throttle), .axis(s_throttle));
  scc_scale #(.ADC_BITS(ADC_BITS)) u_scale_aux_one  (.sample(a_aux_one),  .axis(s_aux_one));
  scc_scale #(.ADC_BITS(ADC_BITS)) u_scale_aux_two  (.sample(a_aux_two),  .axis(s_aux_two));

  scc_throttle u_throttle (
    .clk       (clk),
    .rst       (rst),
    .load      (a_adv),
    .stick     (s_throttle),
    .threshold (cfg.threshold),
    .acc       (b_acc)
  );

  // stage B
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid       <= 1'b0;
      frame_counter <= '0;
    end else begin
      if (b_free) begin
        b_valid <= a_valid;
      end
      if (a_adv) begin
        frame_counter <= frame_counter + SEQ_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      b_roll    <= s_roll;
      b_pitch   <= s_pitch;
      b_yaw     <= s_yaw;
      b_aux_one <= s_aux_one;
      b_aux_two <= s_aux_two;
      b_seq     <= frame_counter;
      b_buttons <= {!a_btn_four, !a_btn_three,
                    a_aux_two > ADC_BITS'(AUX_LIMIT),
                    a_aux_one > ADC_BITS'(AUX_LIMIT)};
    end
  end

  scc_level u_level (
    .acc      (b_acc),
    .deadzone (cfg.deadzone),
    .level    (c_level),
    .duty     (c_duty)
  );

  // stage C: result word
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (c_free) begin
      result_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      raw_roll     <= b_roll;
      raw_pitch    <= b_pitch;
      raw_yaw      <= b_yaw;
      roll         <= calibrate(b_roll, cfg.offset_roll);
      pitch        <= calibrate(b_pitch, cfg.offset_pitch);
      yaw          <= calibrate(b_yaw, cfg.offset_yaw);
      throttle     <= c_level;
      led_duty     <= c_duty;
      sequence_res <= b_seq;
      buttons      <= b_buttons;
      aux_one_axis <= b_aux_one;
      aux_two_axis <= b_aux_two;
    end
  end

`ifndef NO_ASSERTIONS
  a_acc_bound: assert property (@(posedge clk) disable iff (rst)
    b_acc <= ACC_W'(MILLI_FULL))
    else $error("throttle accumulator above full scale");

  a_seq_step: assert property (@(posedge clk) disable iff (rst)
    a_adv |=> frame_counter == $past(frame_counter) + SEQ_W'(1))
    else $error("frame counter did not step once per word");

  a_hold_b: assert property (@(posedge clk) disable iff (rst)
    (b_valid && result_valid && result_stall) |=> b_valid)
    else $error("scaled word lost while result stalled");

  a_deadzone: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (throttle == '0 || throttle >= cfg.deadzone))
    else $error("throttle level inside deadzone");
`endif

endmodule

FILE: verif/tb_top.sv
// tb_top: self-checking bench for stick_channel_conditioner.
// Predicts every result word in-bench and checks it field by field against the DUT.
// Depends on scc_pkg and the RTL under rtl/core.
module tb_top;
  import scc_pkg::*;

  localparam int ADC_W        = 12;
  localparam int ADC_MAX      = 4095;
  localparam int MID          = 2048;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 4;
  localparam int CLIMB_CAP    = 900;
  localparam int CLIMB_HOLD   = 25;
  localparam int PHASE_WORDS  = 30;
  localparam int THR_MIXED    = 0;
  localparam int THR_CLIMB    = 1;

  typedef struct packed {
    logic [ADC_W-1:0] roll_adc;
    logic [ADC_W-1:0] pitch_adc;
    logic [ADC_W-1:0] yaw_adc;
    logic [ADC_W-1:0] throttle_adc;
    logic [ADC_W-1:0] aux_one_adc;
    logic [ADC_W-1:0] aux_two_adc;
    logic             button_three_level;
    logic             button_four_level;
  } frame_t;

  typedef struct packed {
    logic signed [AXIS_W-1:0] raw_roll;
    logic signed [AXIS_W-1:0] raw_pitch;
    logic signed [AXIS_W-1:0] raw_yaw;
    logic signed [AXIS_W-1:0] roll;
    logic signed [AXIS_W-1:0] pitch;
    logic signed [AXIS_W-1:0] yaw;
    logic [LEVEL_W-1:0]       throttle;
    logic [DUTY_W-1:0]        led_duty;
    logic [SEQ_W-1:0]         sequence_res;
    logic [3:0]               buttons;
    logic signed [AXIS_W-1:0] aux_one_axis;
    logic signed [AXIS_W-1:0] aux_two_axis;
  } conditioned_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  wr_index = '0;
  logic [CFG_DATA_W-1:0] wr_data = '0;
  logic                  frame_valid = 1'b0;
  logic                  frame_stall;
  logic [ADC_W-1:0]      roll_adc = '0;
  logic [ADC_W-1:0]      pitch_adc = '0;
  logic [ADC_W-1:0]      yaw_adc = '0;
  logic [ADC_W-1:0]      throttle_adc = '0;
  logic [ADC_W-1:0]      aux_one_adc = '0;
  logic [ADC_W-1:0]      aux_two_adc = '0;
  logic                  button_three_level = 1'b1;
  logic                  button_four_level = 1'b1;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  logic signed [AXIS_W-1:0] raw_roll, raw_pitch, raw_yaw;
  logic signed [AXIS_W-1:0] roll, pitch, yaw;
  logic [LEVEL_W-1:0]       throttle;
  logic [DUTY_W-1:0]        led_duty;
  logic [SEQ_W-1:0]         sequence_res;
  logic [3:0]               buttons;
  logic signed [AXIS_W-1:0] aux_one_axis, aux_two_axis;

  // in-bench copy of the block's configuration and state
  int             off_roll_m = 0;
  int             off_pitch_m = 0;
  int             off_yaw_m = 0;
  int             deadzone_m = DEADZONE_RESET;
  int             threshold_m = THRESHOLD_RESET;
  int             throttle_acc_m = 0;
  logic [SEQ_W-1:0] frame_count_m = '0;

  conditioned_t pending_words[$];
  int           errors = 0;
  int           cycle_count = 0;
  bit           sender_steady = 1'b0;
  bit           receiver_quiet = 1'b0;
  int           burst_left = 1;
  int           stall_run = 0;
  int           free_run = 0;

  stick_channel_conditioner #(.ADC_BITS(ADC_W)) u_dut (
    .clk(clk), .rst(rst),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .frame_valid(frame_valid), .frame_stall(frame_stall),
    .roll_adc(roll_adc), .pitch_adc(pitch_adc), .yaw_adc(yaw_adc),
    .throttle_adc(throttle_adc), .aux_one_adc(aux_one_adc), .aux_two_adc(aux_two_adc),
    .button_three_level(button_three_level), .button_four_level(button_four_level),
    .result_valid(result_valid), .result_stall(result_stall),
    .raw_roll(raw_roll), .raw_pitch(raw_pitch), .raw_yaw(raw_yaw),
    .roll(roll), .pitch(pitch), .yaw(yaw),
    .throttle(throttle), .led_duty(led_duty), .sequence_res(sequence_res),
    .buttons(buttons), .aux_one_axis(aux_one_axis), .aux_two_axis(aux_two_axis)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int scale_sample(logic [ADC_W-1:0] x);
    int v;
    v = x;
    return ((v - MID) * 1000) / MID;
  endfunction

  function automatic int clamp_axis(int raw, int off);
    int c;
    c = raw - off;
    if (c > AXIS_LIMIT) c = AXIS_LIMIT;
    if (c < -AXIS_LIMIT) c = -AXIS_LIMIT;
    return c;
  endfunction

  function automatic conditioned_t condition_frame(frame_t f);
    conditioned_t r;
    int sr, sp, sy, st, acc, lvl, duty;
    logic [3:0] btn;
    sr = scale_sample(f.roll_adc);
    sp = scale_sample(f.pitch_adc);
    sy = scale_sample(f.yaw_adc);
    st = scale_sample(f.throttle_adc);
    acc = throttle_acc_m;
    if (st > threshold_m || st < -threshold_m) acc += 2 * st;
    if (acc < 0) acc = 0;
    if (acc > MILLI_FULL) acc = MILLI_FULL;
    throttle_acc_m = acc;
    lvl = (acc < deadzone_m * 1000) ? 0 : acc / 1000;
    duty = acc * 255 / MILLI_FULL;
    btn = '0;
    if (f.aux_one_adc > AUX_LIMIT) btn[0] = 1'b1;
    if (f.aux_two_adc > AUX_LIMIT) btn[1] = 1'b1;
    if (!f.button_three_level) btn[2] = 1'b1;
    if (!f.button_four_level) btn[3] = 1'b1;
    r.raw_roll     = AXIS_W'(sr);
    r.raw_pitch    = AXIS_W'(sp);
    r.raw_yaw      = AXIS_W'(sy);
    r.roll         = AXIS_W'(clamp_axis(sr, off_roll_m));
    r.pitch        = AXIS_W'(clamp_axis(sp, off_pitch_m));
    r.yaw          = AXIS_W'(clamp_axis(sy, off_yaw_m));
    r.throttle     = LEVEL_W'(lvl);
    r.led_duty     = DUTY_W'(duty);
    r.sequence_res = frame_count_m;
    r.buttons      = btn;
    r.aux_one_axis = AXIS_W'(scale_sample(f.aux_one_adc));
    r.aux_two_axis = AXIS_W'(scale_sample(f.aux_two_adc));
    frame_count_m  = frame_count_m + 1'b1;
    return r;
  endfunction

  function automatic frame_t mk_frame(int r, int p, int y, int t, int a1, int a2,
                                      bit b3, bit b4);
    frame_t f;
    f.roll_adc = ADC_W'(r);
    f.pitch_adc = ADC_W'(p);
    f.yaw_adc = ADC_W'(y);
    f.throttle_adc = ADC_W'(t);
    f.aux_one_adc = ADC_W'(a1);
    f.aux_two_adc = ADC_W'(a2);
    f.button_three_level = b3;
    f.button_four_level = b4;
    return f;
  endfunction

  function automatic frame_t rand_frame(int mode);
    frame_t f;
    int x, s;
    f.roll_adc = ADC_W'($urandom);
    f.pitch_adc = ADC_W'($urandom);
    f.yaw_adc = ADC_W'($urandom);
    f.aux_one_adc = ($urandom_range(0, 3) == 0) ? ADC_W'($urandom_range(496, 505))
                                                : ADC_W'($urandom);
    f.aux_two_adc = ($urandom_range(0, 3) == 0) ? ADC_W'($urandom_range(496, 505))
                                                : ADC_W'($urandom);
    f.button_three_level = 1'($urandom);
    f.button_four_level = 1'($urandom);
    if (mode == THR_CLIMB) begin
      x = ($urandom_range(0, 9) != 0) ? $urandom_range(4000, ADC_MAX)
                                      : $urandom_range(0, ADC_MAX);
    end else begin
      case ($urandom_range(0, 3))
        0: x = $urandom_range(0, ADC_MAX);
        1: x = $urandom_range(0, 1) ? $urandom_range(0, 40) : $urandom_range(4055, ADC_MAX);
        2: begin
          // land just around the rate threshold on either side of center
          s = threshold_m * MID / 1000 + int'($urandom_range(0, 6)) - 3;
          x = $urandom_range(0, 1) ? MID + s : MID - s;
        end
        default: x = MID + int'($urandom_range(0, 128)) - 64;
      endcase
    end
    if (x < 0) x = 0;
    if (x > ADC_MAX) x = ADC_MAX;
    f.throttle_adc = ADC_W'(x);
    return f;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_offset();
    int v;
    case ($urandom_range(0, 7))
      0: v = $urandom_range(0, 1) ? -1024 : 1023;
      1: v = $urandom_range(0, 1) ? -AXIS_LIMIT : AXIS_LIMIT - 1;
      default: v = int'($urandom_range(0, 1999)) - AXIS_LIMIT;
    endcase
    return CFG_DATA_W'(v);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_limit();
    logic [CFG_DATA_W-1:0] v;
    v = ($urandom_range(0, 5) == 0) ? CFG_DATA_W'($urandom_range(1001, 1023))
                                    : CFG_DATA_W'($urandom_range(0, 1000));
    // bit 10 is outside the 10-bit registers and must be dropped
    v[CFG_DATA_W-1] = 1'($urandom);
    return v;
  endfunction

  // leaves wr_en high; the caller lowers it after the last write
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= data;
    @(posedge clk);
    case (idx)
      REG_OFFSET_ROLL:  off_roll_m = $signed(data);
      REG_OFFSET_PITCH: off_pitch_m = $signed(data);
      REG_OFFSET_YAW:   off_yaw_m = $signed(data);
      REG_DEADZONE:     deadzone_m = data[9:0];
      REG_THRESHOLD:    threshold_m = data[9:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(logic [CFG_DATA_W-1:0] off_r, logic [CFG_DATA_W-1:0] off_p,
                                logic [CFG_DATA_W-1:0] off_y, logic [CFG_DATA_W-1:0] dz,
                                logic [CFG_DATA_W-1:0] thr);
    write_reg(REG_OFFSET_ROLL, off_r);
    write_reg(REG_OFFSET_PITCH, off_p);
    write_reg(REG_OFFSET_YAW, off_y);
    write_reg(REG_DEADZONE, dz);
    write_reg(REG_THRESHOLD, thr);
    wr_en <= 1'b0;
  endtask

  task automatic send_frame(frame_t f);
    frame_valid <= 1'b1;
    roll_adc <= f.roll_adc;
    pitch_adc <= f.pitch_adc;
    yaw_adc <= f.yaw_adc;
    throttle_adc <= f.throttle_adc;
    aux_one_adc <= f.aux_one_adc;
    aux_two_adc <= f.aux_two_adc;
    button_three_level <= f.button_three_level;
    button_four_level <= f.button_four_level;
    @(posedge clk);
    while (frame_stall) @(posedge clk);
    pending_words.push_back(condition_frame(f));
    if (!sender_steady) begin
      burst_left--;
      if (burst_left <= 0) begin
        frame_valid <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        burst_left = $urandom_range(1, 16);
      end
    end
  endtask

  task automatic wait_idle();
    frame_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic check_field(string name, logic signed [31:0] want, logic signed [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // reset values, axis scaling at the extremes and center, aux and rate thresholds
  task automatic test_reset_defaults();
    send_frame(mk_frame(MID, MID, MID, MID, MID, MID, 1'b1, 1'b1));
    send_frame(mk_frame(0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
    send_frame(mk_frame(ADC_MAX, ADC_MAX, ADC_MAX, ADC_MAX, ADC_MAX, ADC_MAX, 1'b1, 1'b0));
    send_frame(mk_frame(2047, 2049, 2050, 2253, 500, 501, 1'b0, 1'b1));
    send_frame(mk_frame(2051, 1, 4094, 2255, 501, 500, 1'b1, 1'b0));
    send_frame(mk_frame(1, 4094, 2047, 1843, 0, ADC_MAX, 1'b0, 1'b0));
    send_frame(mk_frame(ADC_MAX, 0, 2049, 1841, ADC_MAX, 0, 1'b1, 1'b1));
    wait_idle();
  endtask

  // offsets at and past the stated range drive the calibrated axes into the clamp
  task automatic test_offset_clamp();
    apply_settings(CFG_DATA_W'(-1024), CFG_DATA_W'(1023), CFG_DATA_W'(999), '0, '0);
    send_frame(mk_frame(0, 0, 0, 2049, 0, 0, 1'b0, 1'b1));
    send_frame(mk_frame(ADC_MAX, ADC_MAX, ADC_MAX, 2052, ADC_MAX, ADC_MAX, 1'b1, 1'b0));
    send_frame(mk_frame(MID, MID, MID, ADC_MAX, 501, 501, 1'b0, 1'b0));
    wait_idle();
    apply_settings(CFG_DATA_W'(1023), CFG_DATA_W'(-1024), CFG_DATA_W'(-AXIS_LIMIT),
                   CFG_DATA_W'(1), CFG_DATA_W'(0));
    send_frame(mk_frame(0, 0, 0, ADC_MAX, 0, 0, 1'b1, 1'b1));
    send_frame(mk_frame(ADC_MAX, ADC_MAX, ADC_MAX, 0, ADC_MAX, ADC_MAX, 1'b0, 1'b0));
    wait_idle();
  endtask

  // writes to unused indexes must leave every register alone
  task automatic test_unknown_index();
    for (int i = REG_THRESHOLD + 1; i < (1 << CFG_IDX_W); i++)
      write_reg(CFG_IDX_W'(i), CFG_DATA_W'($urandom));
    wr_en <= 1'b0;
    repeat (4) send_frame(rand_frame(THR_MIXED));
    wait_idle();
  endtask

  // threshold and deadzone at and above full scale freeze and blank the throttle
  task automatic test_large_limits();
    apply_settings(rand_offset(), rand_offset(), rand_offset(),
                   CFG_DATA_W'(1023), CFG_DATA_W'(1023));
    send_frame(mk_frame(ADC_MAX, 0, MID, ADC_MAX, 0, ADC_MAX, 1'b0, 1'b1));
    send_frame(mk_frame(0, ADC_MAX, MID, 0, ADC_MAX, 0, 1'b1, 1'b0));
    send_frame(mk_frame(MID, MID, 0, ADC_MAX, 500, 500, 1'b0, 1'b0));
    wait_idle();
    apply_settings(rand_offset(), rand_offset(), rand_offset(),
                   CFG_DATA_W'(1000), CFG_DATA_W'(1000));
    send_frame(mk_frame(ADC_MAX, ADC_MAX, ADC_MAX, ADC_MAX, ADC_MAX, ADC_MAX, 1'b1, 1'b1));
    send_frame(mk_frame(0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
    wait_idle();
  endtask

  // push the accumulator through the deadzone up to its upper clamp and hold there
  task automatic test_throttle_climb();
    int n, held;
    n = 0;
    held = 0;
    sender_steady = 1'b0;
    receiver_quiet = 1'b0;
    apply_settings(rand_offset(), rand_offset(), rand_offset(),
                   CFG_DATA_W'($urandom_range(0, 1000)), CFG_DATA_W'($urandom_range(0, 300)));
    while (n < CLIMB_CAP && held < CLIMB_HOLD) begin
      send_frame(rand_frame(THR_CLIMB));
      n++;
      if (throttle_acc_m == MILLI_FULL) held++;
    end
    wait_idle();
  endtask

  // several register settings, the extremes first, with mixed throttle content
  task automatic test_random_settings();
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: apply_settings(CFG_DATA_W'(-1024), CFG_DATA_W'(1023), '0, '0, '0);
        1: apply_settings(CFG_DATA_W'(1023), CFG_DATA_W'(-1024), CFG_DATA_W'(-AXIS_LIMIT),
                          CFG_DATA_W'(1023), CFG_DATA_W'(1023));
        2: apply_settings(CFG_DATA_W'(AXIS_LIMIT - 1), CFG_DATA_W'(-AXIS_LIMIT), rand_offset(),
                          CFG_DATA_W'(1000), CFG_DATA_W'(1000));
        default: apply_settings(rand_offset(), rand_offset(), rand_offset(),
                                rand_limit(), rand_limit());
      endcase
      sender_steady = (ph % 3 == 0) ? 1'b1 : 1'($urandom);
      receiver_quiet = (ph % 3 == 0) ? 1'b1 : 1'($urandom_range(0, 3) == 0);
      repeat (PHASE_WORDS) send_frame(rand_frame(THR_MIXED));
      wait_idle();
    end
  endtask

  always @(posedge clk) begin
    if (receiver_quiet) begin
      result_stall <= 1'b0;
    end else if (stall_run > 0) begin
      stall_run <= stall_run - 1;
      result_stall <= 1'b1;
    end else if (free_run > 0) begin
      free_run <= free_run - 1;
      result_stall <= 1'b0;
    end else begin
      stall_run <= $urandom_range(1, 4);
      free_run <= ($urandom_range(0, 7) == 0) ? $urandom_range(15, 40) : $urandom_range(0, 6);
      result_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    conditioned_t w;
    if (!rst && result_valid && !result_stall) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual sequence %0d",
                 $time, sequence_res);
        errors++;
      end else begin
        w = pending_words.pop_front();
        check_field("raw_roll", w.raw_roll, raw_roll);
        check_field("raw_pitch", w.raw_pitch, raw_pitch);
        check_field("raw_yaw", w.raw_yaw, raw_yaw);
        check_field("roll", w.roll, roll);
        check_field("pitch", w.pitch, pitch);
        check_field("yaw", w.yaw, yaw);
        check_field("throttle", w.throttle, throttle);
        check_field("led_duty", w.led_duty, led_duty);
        check_field("sequence_res", w.sequence_res, sequence_res);
        check_field("buttons", w.buttons, buttons);
        check_field("aux_one_axis", w.aux_one_axis, aux_one_axis);
        check_field("aux_two_axis", w.aux_two_axis, aux_two_axis);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_offset_clamp();
    test_unknown_index();
    test_large_limits();
    test_throttle_climb();
    test_random_settings();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending_words.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
